[rtl/core/bti_pkg.sv]
`default_nettype none
package bti_pkg;

   localparam int DATA_W    = 32;
   localparam int SIZE_W    = 7;
   localparam int IDX_W     = 7;
   localparam int ENTRY_W   = 12;
   localparam int CSR_IDX_W = 3;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAR_MIN   = 3'd0,
      CSR_PERP_MIN  = 3'd1,
      CSR_PAR_INV   = 3'd2,
      CSR_PERP_INV  = 3'd3,
      CSR_PAR_SIZE  = 3'd4,
      CSR_PERP_SIZE = 3'd5,
      CSR_SEPARABLE = 3'd6
   } csr_index_type;

   typedef struct packed {
      mode_type                   mode;
      logic [ENTRY_W-1:0]         entry_index;
      logic [DATA_W-1:0]          entry_value;
      logic signed [DATA_W-1:0]   par_coord;
      logic signed [DATA_W-1:0]   perp_coord;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] interp_value;
      logic              in_grid;
   } rsp_type;

   // Table lookup request: cell indices and addressing mode.
   typedef struct packed {
      logic              sep;
      logic [IDX_W-1:0]  par_idx;
      logic [IDX_W-1:0]  perp_idx;
      logic [SIZE_W-1:0] par_n;
   } lookup_type;

   // Two neighbor pairs, each ordered lower address first.
   typedef struct packed {
      logic [DATA_W-1:0] a_lo;
      logic [DATA_W-1:0] a_hi;
      logic [DATA_W-1:0] b_lo;
      logic [DATA_W-1:0] b_hi;
   } table_words_type;

endpackage
`default_nettype wire

[rtl/core/bti_axis.sv]
`default_nettype none
module bti_axis
   import bti_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic signed [DATA_W-1:0] coord,
   input  logic [DATA_W-1:0]        axis_min,
   input  logic [DATA_W-1:0]        inv_step,
   input  logic [SIZE_W-1:0]        size_n,
   output logic                     ok,
   output logic [IDX_W-1:0]         idx,
   output logic [FRAC_BITS-1:0]     frac
);

   localparam int PROD_W = 2 * DATA_W;
   localparam int CELL_W = PROD_W - 2 * FRAC_BITS;

   logic [DATA_W:0]        diff_in, diff_ff;
   logic [PROD_W-1:0]      prod_in, prod_ff;
   logic                   neg_ff;
   logic [CELL_W-1:0]      grid_pos;
   logic                   ok_in, ok_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [FRAC_BITS-1:0]   frac_ff;

   assign diff_in = {coord[DATA_W-1], coord} - {axis_min[DATA_W-1], axis_min};
   assign prod_in = diff_ff[DATA_W-1:0] * inv_step;

   assign grid_pos = prod_ff[PROD_W-1:2*FRAC_BITS];
   // upper neighbor must exist: cell index at most size-2
   assign ok_in = !neg_ff && (size_n >= SIZE_W'(2)) &&
                  (grid_pos <= CELL_W'(size_n - SIZE_W'(2)));

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      neg_ff  <= diff_ff[DATA_W];
      prod_ff <= prod_in;
      ok_ff   <= ok_in;
      idx_ff  <= grid_pos[IDX_W-1:0];
      frac_ff <= prod_ff[2*FRAC_BITS-1:FRAC_BITS];
   end

   assign ok   = ok_ff;
   assign idx  = idx_ff;
   assign frac = frac_ff;

endmodule
`default_nettype wire

[rtl/core/bti_table.sv]
`default_nettype none
module bti_table
   import bti_pkg::*;
#(
   parameter int PAR_MAX  = 64,
   parameter int PERP_MAX = 64
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ENTRY_W-1:0] wr_addr,
   input  logic [DATA_W-1:0]  wr_data,
   input  lookup_type         lookup,
   output table_words_type    words
);

   localparam int DEPTH      = PAR_MAX * PERP_MAX;
   localparam int AW         = $clog2(DEPTH);
   localparam int BW         = AW - 1;
   localparam int BANK_DEPTH = (DEPTH + 1) / 2;
   localparam int XW         = (AW > 15) ? AW : 15;

   logic [DATA_W-1:0] even_mem [BANK_DEPTH];
   logic [DATA_W-1:0] odd_mem  [BANK_DEPTH];

   logic              wr_hit;
   logic [AW-1:0]     waddr;
   logic [XW-1:0]     base_a, base_b;
   logic [AW-1:0]     addr_a, addr_b, next_a, next_b;
   logic [BW-1:0]     even_a, odd_a, even_b, odd_b;
   logic [DATA_W-1:0] even_a_ff, odd_a_ff, even_b_ff, odd_b_ff;
   logic              par_a_ff, par_b_ff;

   // loads beyond the table are dropped
   assign wr_hit = wr_en && ({20'b0, wr_addr} < 32'(DEPTH));
   assign waddr  = AW'(wr_addr);

   always_ff @(posedge clock) begin
      if (wr_hit && !waddr[0]) begin
         even_mem[waddr[AW-1:1]] <= wr_data;
      end
      if (wr_hit && waddr[0]) begin
         odd_mem[waddr[AW-1:1]] <= wr_data;
      end
   end

   // pair A: lower row or par table; pair B: upper row or perp table
   always_comb begin
      base_a = XW'(lookup.perp_idx) * XW'(lookup.par_n) + XW'(lookup.par_idx);
      base_b = base_a + XW'(lookup.par_n);
      if (lookup.sep) begin
         base_a = XW'(lookup.par_idx);
         base_b = XW'(lookup.par_n) + XW'(lookup.perp_idx);
      end
   end

   assign addr_a = AW'(base_a);
   assign addr_b = AW'(base_b);
   assign next_a = addr_a + AW'(1);
   assign next_b = addr_b + AW'(1);

   // consecutive addresses always fall in opposite banks
   assign odd_a  = addr_a[AW-1:1];
   assign even_a = addr_a[0] ? next_a[AW-1:1] : addr_a[AW-1:1];
   assign odd_b  = addr_b[AW-1:1];
   assign even_b = addr_b[0] ? next_b[AW-1:1] : addr_b[AW-1:1];

   always_ff @(posedge clock) begin
      even_a_ff <= even_mem[even_a];
      even_b_ff <= even_mem[even_b];
      odd_a_ff  <= odd_mem[odd_a];
      odd_b_ff  <= odd_mem[odd_b];
      par_a_ff  <= addr_a[0];
      par_b_ff  <= addr_b[0];
   end

   assign words.a_lo = par_a_ff ? odd_a_ff  : even_a_ff;
   assign words.a_hi = par_a_ff ? even_a_ff : odd_a_ff;
   assign words.b_lo = par_b_ff ? odd_b_ff  : even_b_ff;
   assign words.b_hi = par_b_ff ? even_b_ff : odd_b_ff;

endmodule
`default_nettype wire

[rtl/core/bti_blend.sv]
`default_nettype none
module bti_blend
   import bti_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  table_words_type      words,
   input  logic                 ok,
   input  logic                 sep,
   input  logic [FRAC_BITS-1:0] par_frac,
   input  logic [FRAC_BITS-1:0] perp_frac,
   output rsp_type              result
);

   localparam int PW   = DATA_W + FRAC_BITS + 1;
   localparam int SP_W = 2 * DATA_W;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [FRAC_BITS:0]   wa, wb, wq;
   logic [FRAC_BITS-1:0] fb;
   logic [PW-1:0]        alo_in, ahi_in, blo_in, bhi_in;
   logic [PW-1:0]        alo_ff, ahi_ff, blo_ff, bhi_ff;
   logic [PW-1:0]        sum_a, sum_b, sum_m;
   logic [DATA_W-1:0]    lo_ff, hi_ff;
   logic [PW-1:0]        mlo_in, mhi_in, mlo_ff, mhi_ff;
   logic [SP_W-1:0]      sp_in, sp_ff;
   logic [DATA_W-1:0]    twod, sepv, val_in;
   logic                 ok1_ff, ok2_ff, ok3_ff;
   logic [FRAC_BITS-1:0] fq1_ff, fq2_ff;
   rsp_type              result_ff;

   // first level: weight each neighbor pair
   assign fb     = sep ? perp_frac : par_frac;
   assign wa     = ONE - {1'b0, par_frac};
   assign wb     = ONE - {1'b0, fb};
   assign alo_in = words.a_lo * wa;
   assign ahi_in = words.a_hi * par_frac;
   assign blo_in = words.b_lo * wb;
   assign bhi_in = words.b_hi * fb;

   assign sum_a = alo_ff + ahi_ff;
   assign sum_b = blo_ff + bhi_ff;

   // second level: perp lerp, or product of the two 1-D results
   assign wq     = ONE - {1'b0, fq2_ff};
   assign mlo_in = lo_ff * wq;
   assign mhi_in = hi_ff * fq2_ff;
   assign sp_in  = lo_ff * hi_ff;

   assign sum_m = mlo_ff + mhi_ff;
   assign twod  = sum_m[FRAC_BITS +: DATA_W];
   assign sepv  = (|sp_ff[SP_W-1:FRAC_BITS+DATA_W]) ? '1 : sp_ff[FRAC_BITS +: DATA_W];
   assign val_in = ok3_ff ? (sep ? sepv : twod) : '0;

   always_ff @(posedge clock) begin
      alo_ff <= alo_in;
      ahi_ff <= ahi_in;
      blo_ff <= blo_in;
      bhi_ff <= bhi_in;
      ok1_ff <= ok;
      fq1_ff <= perp_frac;

      lo_ff  <= sum_a[FRAC_BITS +: DATA_W];
      hi_ff  <= sum_b[FRAC_BITS +: DATA_W];
      ok2_ff <= ok1_ff;
      fq2_ff <= fq1_ff;

      mlo_ff <= mlo_in;
      mhi_ff <= mhi_in;
      sp_ff  <= sp_in;
      ok3_ff <= ok2_ff;

      result_ff.interp_value <= val_in;
      result_ff.in_grid      <= ok3_ff;
   end

   assign result = result_ff;

endmodule
`default_nettype wire

[rtl/core/bilinear_table_interpolator_core.sv]
`default_nettype none
// Bilinear table interpolator. Takes one request per clock, every clock:
// busy never rises. A load request writes one table sample; a query
// request returns one result on rsp_data with rsp_strobe high for one
// cycle, in request order. There is no way to stall the result side, so
// the receiver must take every strobe. Loads reach the table at the same
// pipeline point where queries read it, so a query always sees every load
// accepted before it and none after. The single-cycle rate is set by the
// sample table: two banks (even and odd address) with two read ports each
// deliver the four neighbor samples of one query per clock. The table is
// not cleared by reset; a query must only touch entries that were loaded.
// Write the csr_ registers only while no query is in flight.
module bilinear_table_interpolator_core
   import bti_pkg::*;
#(
   parameter int PAR_MAX   = 64,
   parameter int PERP_MAX  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int PAR_CAP  = (PAR_MAX > 127) ? 127 : PAR_MAX;
   localparam int PERP_CAP = (PERP_MAX > 127) ? 127 : PERP_MAX;

   logic [DATA_W-1:0]    par_min_ff, perp_min_ff, par_inv_ff, perp_inv_ff;
   logic [SIZE_W-1:0]    par_size_ff, perp_size_ff;
   logic                 separable_ff;
   logic [SIZE_W-1:0]    par_n, perp_n;

   logic                 accept;
   logic [7:0]           qv_ff, qv_in;
   logic [2:0]           ld_ff, ld_in;
   logic [ENTRY_W-1:0]   idx1_ff, idx2_ff, idx3_ff;
   logic [DATA_W-1:0]    val1_ff, val2_ff, val3_ff;

   logic                 par_ok, perp_ok;
   logic [IDX_W-1:0]     par_idx, perp_idx;
   logic [FRAC_BITS-1:0] par_frac, perp_frac;
   logic                 ok4_ff;
   logic [FRAC_BITS-1:0] fp4_ff, fq4_ff;
   lookup_type           lookup;
   table_words_type      tbl_words;
   logic                 tbl_wr_en;

   // the pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         par_min_ff   <= '0;
         perp_min_ff  <= '0;
         par_inv_ff   <= DATA_W'(1) << FRAC_BITS;
         perp_inv_ff  <= DATA_W'(1) << FRAC_BITS;
         par_size_ff  <= SIZE_W'(64);
         perp_size_ff <= SIZE_W'(64);
         separable_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAR_MIN:   par_min_ff   <= csr_wdata;
            CSR_PERP_MIN:  perp_min_ff  <= csr_wdata;
            CSR_PAR_INV:   par_inv_ff   <= csr_wdata;
            CSR_PERP_INV:  perp_inv_ff  <= csr_wdata;
            CSR_PAR_SIZE:  par_size_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_PERP_SIZE: perp_size_ff <= csr_wdata[SIZE_W-1:0];
            CSR_SEPARABLE: separable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamp the configured sizes to the table dimensions
   assign par_n  = (par_size_ff > SIZE_W'(PAR_CAP)) ? SIZE_W'(PAR_CAP) : par_size_ff;
   assign perp_n = (perp_size_ff > SIZE_W'(PERP_CAP)) ? SIZE_W'(PERP_CAP) : perp_size_ff;

   assign qv_in = {qv_ff[6:0], accept && (req_data.mode == MODE_QUERY)};
   assign ld_in = {ld_ff[1:0], accept && (req_data.mode == MODE_LOAD)};

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff <= '0;
         ld_ff <= '0;
      end else begin
         qv_ff <= qv_in;
         ld_ff <= ld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= req_data.entry_index;
      val1_ff <= req_data.entry_value;
      idx2_ff <= idx1_ff;
      val2_ff <= val1_ff;
      idx3_ff <= idx2_ff;
      val3_ff <= val2_ff;
      ok4_ff  <= par_ok && perp_ok;
      fp4_ff  <= par_frac;
      fq4_ff  <= perp_frac;
   end

   bti_axis #(.FRAC_BITS(FRAC_BITS)) u_par_axis (
      .clock    (clock),
      .coord    (req_data.par_coord),
      .axis_min (par_min_ff),
      .inv_step (par_inv_ff),
      .size_n   (par_n),
      .ok       (par_ok),
      .idx      (par_idx),
      .frac     (par_frac)
   );

   bti_axis #(.FRAC_BITS(FRAC_BITS)) u_perp_axis (
      .clock    (clock),
      .coord    (req_data.perp_coord),
      .axis_min (perp_min_ff),
      .inv_step (perp_inv_ff),
      .size_n   (perp_n),
      .ok       (perp_ok),
      .idx      (perp_idx),
      .frac     (perp_frac)
   );

   assign lookup.sep      = separable_ff;
   assign lookup.par_idx  = par_idx;
   assign lookup.perp_idx = perp_idx;
   assign lookup.par_n    = par_n;
   assign tbl_wr_en       = ld_ff[2];

   bti_table #(.PAR_MAX(PAR_MAX), .PERP_MAX(PERP_MAX)) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (idx3_ff),
      .wr_data (val3_ff),
      .lookup  (lookup),
      .words   (tbl_words)
   );

   bti_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock     (clock),
      .words     (tbl_words),
      .ok        (ok4_ff),
      .sep       (separable_ff),
      .par_frac  (fp4_ff),
      .perp_frac (fq4_ff),
      .result    (rsp_data)
   );

   assign rsp_strobe = qv_ff[7];

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept && (req_data.mode == MODE_QUERY), 8))
      else $error("result strobe without a matching query request");

   a_write_from_load: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> $past(accept && (req_data.mode == MODE_LOAD), 3))
      else $error("table write without a matching load request");

   a_bilinear_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.in_grid && !separable_ff) |->
         ((rsp_data.interp_value <= $past(tbl_words.a_lo, 4)) ||
          (rsp_data.interp_value <= $past(tbl_words.a_hi, 4)) ||
          (rsp_data.interp_value <= $past(tbl_words.b_lo, 4)) ||
          (rsp_data.interp_value <= $past(tbl_words.b_hi, 4))))
      else $error("2-D result exceeds all four neighbor samples");

endmodule
`default_nettype wire
